>>> hw/rtl/oqsd_pkg.sv
// ----------------------------------------------------------------------------
// oqsd_pkg: shared types and constants for the ordered queue
// Sizes, request and status codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package oqsd_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH  = 16;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // entry address
  localparam int CW     = $clog2(DEPTH + 1);                // entry count 0..DEPTH
  localparam int VAL_W  = 32;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;
  localparam int POS_W  = 4;
  localparam int IN_DW  = 40;  // opcode + value, padded to bytes
  localparam int OUT_DW = 40;  // status + result_value + position, padded

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } sts_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // capture a new request
    logic ins;    // append at the tail
    logic scan;   // one step of the search pipeline
    logic shift;  // one step of the compaction pipeline
    logic fin;    // hand the result to the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_find;    // request is a find
    logic hit;        // compared entry matches
    logic scan_end;   // every entry has been compared
    logic shift_end;  // compaction finished
    logic out_free;   // output register can take a word
  } dp_sts_t;

endpackage

>>> hw/rtl/oqsd_ram.sv
// ----------------------------------------------------------------------------
// oqsd_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module oqsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/oqsd_ctrl.sv
// ----------------------------------------------------------------------------
// oqsd_ctrl: request sequencer
// Steps each request through insert or search, compaction after a delete or pop match, and result handoff.
// ----------------------------------------------------------------------------
module oqsd_ctrl
  import oqsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  op_t     in_op,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == OP_INSERT) ? S_INSERT : S_SCAN;
        end
      end
      S_INSERT: begin
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          state_nxt = sts.is_find ? S_DONE : S_SHIFT;
        end else if (sts.scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (sts.shift_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_INSERT: cmd.ins   = 1'b1;
      S_SCAN:   cmd.scan  = 1'b1;
      S_SHIFT:  cmd.shift = 1'b1;
      S_DONE:   cmd.fin   = 1'b1;
      default: ;
    endcase
  end

  // A found entry always ends the search
  a_hit_leaves_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.hit) |=> (state_r == S_DONE || state_r == S_SHIFT))
    else $error("search did not stop on a match");

  // Compaction only follows a successful search
  a_shift_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_SHIFT) |-> $past(sts.hit))
    else $error("compaction started without a match");

  // A finished result is handed over before a new word is taken
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_free) |=> (state_r == S_DONE))
    else $error("left result stage while output was full");

endmodule

>>> hw/rtl/oqsd_dp.sv
// ----------------------------------------------------------------------------
// oqsd_dp: queue storage and search datapath
// Holds the entry memory, count, search and compaction pointers, the result
// fields and the output register.
// ----------------------------------------------------------------------------
module oqsd_dp
  import oqsd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  op_t                     in_op,
  input  logic [VAL_W-1:0]        in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STS_W-1:0]        out_status,
  output logic [VAL_W-1:0]        out_result,
  output logic [POS_W-1:0]        out_position
);

  // Request and working registers
  op_t              op_r;
  logic [VAL_W-1:0] value_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;    // next address to read
  logic [AW-1:0]    pidx_r, pidx_nxt;  // address whose data is on rdata
  logic             pend_r, pend_nxt;  // rdata holds a requested entry
  sts_code_t        status_r, status_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;

  // Output register
  logic             ovalid_r;
  logic [STS_W-1:0] ostatus_r;
  logic [VAL_W-1:0] oresult_r;
  logic [POS_W-1:0] opos_r;

  // Memory port
  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic rd_issue;
  logic full;
  logic hit;

  oqsd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_issue = (idx_r < count_r);
  assign full     = (count_r == CW'(DEPTH));
  assign hit      = pend_r && ((op_r == OP_POP) || (rdata == value_r));

  // Status to the controller
  always_comb begin
    sts.is_find   = (op_r == OP_FIND);
    sts.hit       = hit;
    sts.scan_end  = (idx_r == count_r);
    sts.shift_end = !pend_r && !rd_issue;
    sts.out_free  = !ovalid_r || out_ready;
  end

  // Memory addressing: search and compaction read one entry ahead
  always_comb begin
    raddr = idx_r[AW-1:0];
    we    = 1'b0;
    waddr = pidx_r - AW'(1);
    wdata = rdata;
    if (cmd.ins) begin
      we    = !full;
      waddr = count_r[AW-1:0];
      wdata = value_r;
    end else if (cmd.shift) begin
      we    = pend_r;
    end
  end

  // Next values of the working registers
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    rv_nxt     = rv_r;
    pos_nxt    = pos_r;
    priority if (cmd.load) begin
      idx_nxt    = '0;
      pend_nxt   = 1'b0;
      status_nxt = ST_OK;
      rv_nxt     = '0;
      pos_nxt    = '0;
    end else if (cmd.ins) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end else if (cmd.scan) begin
      pidx_nxt = idx_r[AW-1:0];
      if (hit) begin
        // hold idx at match + 1 and drop the read in flight
        pend_nxt = 1'b0;
        pos_nxt  = pidx_r;
        if (op_r != OP_FIND) begin
          rv_nxt = rdata;
        end
      end else begin
        pend_nxt = rd_issue;
        if (rd_issue) begin
          idx_nxt = idx_r + CW'(1);
        end else begin
          status_nxt = ST_MISS;
        end
      end
    end else if (cmd.shift) begin
      pidx_nxt = idx_r[AW-1:0];
      pend_nxt = rd_issue;
      if (rd_issue) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (!pend_r && !rd_issue) begin
        count_nxt = count_r - CW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      if (cmd.fin && sts.out_free) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      value_r <= in_value;
    end
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    status_r <= status_nxt;
    rv_r     <= rv_nxt;
    pos_r    <= pos_nxt;
    if (cmd.fin && sts.out_free) begin
      ostatus_r <= status_r;
      oresult_r <= rv_r;
      opos_r    <= POS_W'(pos_r);
    end
  end

  assign out_valid    = ovalid_r;
  assign out_status   = ostatus_r;
  assign out_result   = oresult_r;
  assign out_position = opos_r;

  // Count stays within capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // Count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r + CW'(1) == $past(count_r)))
    else $error("entry count jumped");

  // Data on the read port always belongs to a live entry
  a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (CW'(pidx_r) < count_r))
    else $error("compared or moved an entry beyond the count");

endmodule

>>> hw/rtl/ordered_queue_with_search_delete.sv
// ----------------------------------------------------------------------------
// ordered_queue_with_search_delete: bounded ordered queue with search/delete
// Keeps up to DEPTH signed 32-bit entries in arrival order in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word carries an opcode (insert, find, delete, pop) and a
//   value; each request gives exactly one result word with a status, the
//   popped or deleted value and the position of the matched entry.
//   A new request is taken only when the previous one has left the
//   sequencer; a finished result may still wait in the output register.
//   Insert appends at the tail and hands over its result. Find searches
//   from the front and stops at the first match or at the end of the
//   queue. Delete and pop add a compaction pass after the match. The
//   single read port of the entry memory sets the pace: search and
//   compaction each move one entry per cycle.
//   Reset empties the queue; memory contents are not cleared, since only
//   entries below the count are ever read.
//   When the receiver stalls, the result holds in the output register and
//   the block stops taking requests after the next one is finished.
// ----------------------------------------------------------------------------
module ordered_queue_with_search_delete
  import oqsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [1:0] opcode, [33:2] value, [39:34] zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // [1:0] status, [33:2] result_value,
                                        // [37:34] position, [39:38] zero
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  op_t              in_op;
  logic [VAL_W-1:0] in_value;
  logic [STS_W-1:0] out_status;
  logic [VAL_W-1:0] out_result;
  logic [POS_W-1:0] out_position;

  // Unpack the request word
  assign in_op    = op_t'(in_tdata[OP_W-1:0]);
  assign in_value = in_tdata[OP_W +: VAL_W];

  oqsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_op),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  oqsd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_status),
    .out_result   (out_result),
    .out_position (out_position)
  );

  // Pack the result word
  assign out_tdata = {{(OUT_DW - STS_W - VAL_W - POS_W){1'b0}},
                      out_position, out_result, out_status};

endmodule

>>> dv/oqsd_queue_checker.sv
// ----------------------------------------------------------------------------
// oqsd_queue_checker: result checker for the ordered queue
// Watches both stream channels, keeps its own image of the queue contents,
// works out the result word of every accepted request word and compares
// each returned result word field by field against the oldest one waiting.
// ----------------------------------------------------------------------------
module oqsd_queue_checker
  import oqsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [1:0] opcode, [33:2] value, [39:34] zero
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,  // [1:0] status, [33:2] result_value,
                                        // [37:34] position, [39:38] zero
  output int                fail_count,
  output int                pending,
  output int                words_checked,
  output int                full_seen,
  output int                miss_seen,
  output int                peak_fill
);

  typedef struct packed {
    sts_code_t           status;
    logic [VAL_W-1:0]    value;
    logic [POS_W-1:0]    position;
  } result_t;

  // Queue contents, front at index 0
  logic [VAL_W-1:0] queue_image[$];
  // Result words still owed by the block, oldest first
  result_t          owed_results[$];

  initial begin
    fail_count    = 0;
    pending       = 0;
    words_checked = 0;
    full_seen     = 0;
    miss_seen     = 0;
    peak_fill     = 0;
  end

  // Apply one request to the queue image and return its result word
  function automatic result_t apply_request(op_t op, logic [VAL_W-1:0] v);
    result_t r;
    int      hit_idx;
    r.status   = ST_OK;
    r.value    = '0;
    r.position = '0;
    hit_idx    = -1;
    if (op == OP_FIND || op == OP_DELETE) begin
      for (int i = 0; i < queue_image.size(); i++) begin
        if (hit_idx < 0 && queue_image[i] == v) hit_idx = i;
      end
    end
    case (op)
      OP_INSERT: begin
        if (queue_image.size() >= DEPTH) r.status = ST_FULL;
        else queue_image.push_back(v);
      end
      OP_FIND: begin
        if (hit_idx < 0) r.status = ST_MISS;
        else r.position = hit_idx[POS_W-1:0];
      end
      OP_DELETE: begin
        if (hit_idx < 0) begin
          r.status = ST_MISS;
        end else begin
          r.value    = queue_image[hit_idx];
          r.position = hit_idx[POS_W-1:0];
          queue_image.delete(hit_idx);
        end
      end
      default: begin
        if (queue_image.size() == 0) r.status = ST_MISS;
        else r.value = queue_image.pop_front();
      end
    endcase
    return r;
  endfunction

  // Check returned words, then predict newly accepted requests
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.status   = sts_code_t'(out_tdata[1:0]);
        got.value    = out_tdata[33:2];
        got.position = out_tdata[37:34];
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $display("%0t: result_value expected %h got %h", $time, want.value, got.value);
            fail_count++;
          end
          if (got.position !== want.position) begin
            $display("%0t: position expected %0d got %0d", $time, want.position,
                     got.position);
            fail_count++;
          end
          if (out_tdata[39:38] !== 2'b00) begin
            $display("%0t: pad bits expected 0 got %b", $time, out_tdata[39:38]);
            fail_count++;
          end
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_MISS) miss_seen++;
          words_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        owed_results.push_back(apply_request(op_t'(in_tdata[1:0]), in_tdata[33:2]));
        if (queue_image.size() > peak_fill) peak_fill = queue_image.size();
      end
      pending = owed_results.size();
    end
  end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the ordered queue with search and delete
// Sends a directed set of requests (empty pops, extreme values, duplicates,
// a full queue, first and last entry removal) and then about two thousand
// random requests biased toward a small value pool so that finds and
// deletes hit, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb;
  import oqsd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_WORDS = 2000;
  localparam int TAIL_CYCLES  = DEPTH + 8;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  int fail_count;
  int pending;
  int words_checked;
  int full_seen;
  int miss_seen;
  int peak_fill;
  int cycle_count = 0;
  int words_sent  = 0;
  int drain_count = 0;

  logic [VAL_W-1:0] value_pool[8];

  ordered_queue_with_search_delete u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  oqsd_queue_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .full_seen     (full_seen),
    .miss_seen     (miss_seen),
    .peak_fill     (peak_fill)
  );

  // Clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, pending);
      $display("tb failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one; none in quiet stretches
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, with stretches of steady ready
  initial begin : result_sink
    int stall_left;
    bit quiet;
    stall_left = 0;
    quiet      = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycle_count % 256 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall_left = pick_gap(1'b0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Present one request word, hold it until taken, then drop valid and idle for the given gap
  task automatic send_word(input op_t op, input logic [VAL_W-1:0] v, input int gap);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, v, op};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DW'({$urandom, $urandom});
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    while (pending != 0) @(negedge clk);
    drain_count++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // Grow, shrink or balanced mix of operations
  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      0: return (r < 55) ? OP_INSERT : (r < 70) ? OP_FIND : (r < 85) ? OP_DELETE : OP_POP;
      1: return (r < 20) ? OP_INSERT : (r < 40) ? OP_FIND : (r < 70) ? OP_DELETE : OP_POP;
      default: return op_t'(r / 25);
    endcase
  endfunction

  initial begin : stimulus
    logic [VAL_W-1:0] fill_values[16];
    int  mode;
    bit  quiet;
    int  directed_words;
    fill_values = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'd5, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9, 32'd10, 32'd11,
                    32'd5, 32'd12, 32'd13, 32'h1234_5678};
    value_pool  = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, $urandom, $urandom, $urandom};
    mode      = 2;
    quiet     = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty queue: pop, find and delete all miss
    send_word(OP_POP, 32'h0, pick_gap(1'b0));
    send_word(OP_FIND, 32'h0, pick_gap(1'b0));
    send_word(OP_DELETE, 32'd7, pick_gap(1'b0));
    // Fill to capacity with extremes and duplicates, then overflow
    foreach (fill_values[i]) send_word(OP_INSERT, fill_values[i], pick_gap(1'b0));
    send_word(OP_INSERT, 32'd1, pick_gap(1'b0));
    // Last entry, first of several duplicates, then remove both ends
    send_word(OP_FIND, 32'h1234_5678, pick_gap(1'b0));
    send_word(OP_FIND, 32'd5, pick_gap(1'b0));
    send_word(OP_DELETE, 32'h1234_5678, pick_gap(1'b0));
    send_word(OP_DELETE, 32'h8000_0000, pick_gap(1'b0));
    send_word(OP_FIND, 32'hDEAD_BEEF, pick_gap(1'b0));
    send_word(OP_POP, $urandom, pick_gap(1'b0));
    directed_words = words_sent;
    drain_results();

    // Random requests in stretches of differing op mix and pacing
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) begin
        mode  = $urandom_range(0, 2);
        quiet = ($urandom_range(0, 3) == 0);
      end
      if (i % 500 == 250) drain_results();
      send_word(pick_op(mode), pick_value(), pick_gap(quiet));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d directed and %0d random requests, %0d result words checked",
             directed_words, words_sent - directed_words, words_checked);
    $display("%0d full and %0d miss responses, peak fill %0d of %0d, %0d drain pauses",
             full_seen, miss_seen, peak_fill, DEPTH, drain_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> ordered_queue_with_search_delete.f
hw/rtl/oqsd_pkg.sv
hw/rtl/oqsd_ram.sv
hw/rtl/oqsd_ctrl.sv
hw/rtl/oqsd_dp.sv
hw/rtl/ordered_queue_with_search_delete.sv
dv/oqsd_queue_checker.sv
dv/tb.sv
